### rtl/aesd_pkg.sv
// Package for the AES-128 decrypt unit: payload types, S-box tables, GF helpers.
package aesd_pkg;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } out_item_t;

    localparam logic [0:0] REG_KEY_LOW  = 1'b0;
    localparam logic [0:0] REG_KEY_HIGH = 1'b1;

    localparam int unsigned NUM_WORDS = 44;

    function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Multiply by 0x0e, 0x0b, 0x0d, 0x09 share the x2/x4/x8 terms.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] b [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x2;
        logic [7:0] x4;
        logic [7:0] x8;
        for (int i = 0; i < 4; i++) begin
            b[i] = w[8*i +: 8];
            x2 = xtime(b[i]);
            x4 = xtime(x2);
            x8 = xtime(x4);
            m9[i] = x8 ^ b[i];
            mb[i] = x8 ^ x2 ^ b[i];
            md[i] = x8 ^ x4 ^ b[i];
            me[i] = x8 ^ x4 ^ x2;
        end
        return {mb[0] ^ md[1] ^ m9[2] ^ me[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                me[0] ^ mb[1] ^ md[2] ^ m9[3]};
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

### rtl/aesd_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module aesd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 44
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/aesd_round.sv
// One inverse round over a 128-bit state (InvSub, InvShift, optional InvMix).
module aesd_round (
    input  logic [127:0] state,
    input  logic         mix,
    output logic [127:0] result
);

    logic [7:0]  sb [16];
    logic [31:0] col [4];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            // row r of output column j comes from input column j-r
            for (int r = 0; r < 4; r++)
            begin
                sb[4*j+r] = aesd_pkg::inv_sbox(state[32*((j + 4 - r) % 4) + 8*r +: 8]);
            end
            col[j] = {sb[4*j+3], sb[4*j+2], sb[4*j+1], sb[4*j]};
            result[32*j +: 32] = mix ? aesd_pkg::inv_mix_col(col[j]) : col[j];
        end
    end

endmodule

### rtl/aes128_block_decrypt_unit.sv
// Top level: AES-128 decryption with on-demand key expansion, one round per cycle.
// With keys ready, an accepted item gets the initial add, ten inverse rounds, then done;
// busy is high from acceptance through done, and a new item is taken only in idle.
// After reset or a key write the next item first expands the key: 40 words one per cycle,
// then a wait state for the last row to land in memory. rst_n is async active
// low; it restores the reset key and marks keys stale. Receiver cannot stall: done is a pulse.
module aes128_block_decrypt_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  aesd_pkg::in_item_t   din,
    output logic                 busy,
    output logic                 done,
    output aesd_pkg::out_item_t  dout,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [63:0]          cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXP   = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [63:0]   key_low_reg, key_high_reg;
    logic          keys_ready_reg;
    // expansion: word counter and sliding window of last four raw words
    logic [5:0]    wcnt_reg, wcnt_next;
    logic [31:0]   win_reg [4];
    // decryption: round counter, counts down
    //   12 = wait for the last key row, 11 = initial add (row 10),
    //   10..1 = inverse round using row rnd-1, no InvMix at 1
    logic [3:0]    rnd_reg, rnd_next;
    logic [127:0]  st_reg;
    logic [7:0]    rcon_reg;

    // Round-key memory holds 11 rows of 128 bits: row r = words 4r..4r+3
    logic          ram_we;
    logic [3:0]    ram_waddr, ram_raddr;
    logic [127:0]  ram_wdata, ram_rdata;
    logic [127:0]  row_buf_reg;

    aesd_ram #(.WIDTH(128), .DEPTH(11)) u_rk (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [127:0] rnd_out;
    logic [127:0] rnd_in;

    aesd_round u_round (
        .state  (rnd_in),
        .mix    (rnd_reg != 4'd1),
        .result (rnd_out)
    );

    // no key write in the cycle an item is taken, so expansion always sees a settled key
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign busy      = (state_reg != ST_IDLE);
    assign rnd_in    = st_reg;

    // next expanded word from window
    logic [31:0] new_word, tword, mixed_word;
    always_comb
    begin
        tword = win_reg[3];
        if (wcnt_reg[1:0] == 2'd0)
        begin
            tword = {aesd_pkg::fwd_sbox(win_reg[3][7:0]),
                     aesd_pkg::fwd_sbox(win_reg[3][31:24]),
                     aesd_pkg::fwd_sbox(win_reg[3][23:16]),
                     aesd_pkg::fwd_sbox(win_reg[3][15:8])} ^ {24'd0, rcon_reg};
        end
        new_word   = win_reg[0] ^ tword;
        mixed_word = (wcnt_reg < 6'd40) ? aesd_pkg::inv_mix_col(new_word) : new_word;
    end

    // memory write: raw key as row 0 when expansion starts, then each row as its
    // fourth word arrives; read address is the row the next round needs
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wcnt_reg[5:2];
        ram_wdata = {mixed_word, row_buf_reg[95:0]};
        if (state_reg == ST_IDLE && start && !keys_ready_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = 4'd0;
            ram_wdata = {key_high_reg, key_low_reg};
        end
        else if (state_reg == ST_EXP && wcnt_reg[1:0] == 2'd3)
        begin
            ram_we = 1'b1;
        end
        if (rnd_next inside {[4'd11:4'd15]})
        begin
            ram_raddr = 4'd10;
        end
        else if (rnd_next == 4'd0)
        begin
            ram_raddr = 4'd0;
        end
        else
        begin
            ram_raddr = rnd_next - 4'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wcnt_next  = wcnt_reg;
        rnd_next   = rnd_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rnd_next = 4'd10;
                if (start)
                begin
                    if (keys_ready_reg)
                    begin
                        state_next = ST_ROUND;
                        rnd_next   = 4'd11;
                    end
                    else
                    begin
                        state_next = ST_EXP;
                        wcnt_next  = 6'd4;
                    end
                end
            end
            ST_EXP:
            begin
                wcnt_next = wcnt_reg + 6'd1;
                rnd_next  = 4'd10;
                if (wcnt_reg == 6'd43)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = 4'd12;
                end
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg - 4'd1;
                if (rnd_reg == 4'd1)
                begin
                    state_next = ST_DONE;
                    rnd_next   = 4'd10;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
                rnd_next   = 4'd10;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_low_reg    <= 64'h0706050403020100;
            key_high_reg   <= 64'h0f0e0d0c0b0a0908;
            keys_ready_reg <= 1'b0;
            wcnt_reg       <= 6'd0;
            rnd_reg        <= 4'd0;
            rcon_reg       <= 8'h01;
        end
        else
        begin
            state_reg <= state_next;
            wcnt_reg  <= wcnt_next;
            rnd_reg   <= rnd_next;
            if (cfg_valid && cfg_ready)
            begin
                keys_ready_reg <= 1'b0;
                if (cfg_index == aesd_pkg::REG_KEY_LOW)
                begin
                    key_low_reg <= cfg_data;
                end
                else
                begin
                    key_high_reg <= cfg_data;
                end
            end
            if (state_reg == ST_IDLE && start && !keys_ready_reg)
            begin
                rcon_reg <= 8'h01;
            end
            else if (state_reg == ST_EXP && wcnt_reg[1:0] == 2'd0)
            begin
                rcon_reg <= aesd_pkg::xtime(rcon_reg);
            end
            if (state_reg == ST_EXP && wcnt_reg == 6'd43)
            begin
                keys_ready_reg <= 1'b1;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start && !keys_ready_reg)
        begin
            win_reg[0] <= key_low_reg[31:0];
            win_reg[1] <= key_low_reg[63:32];
            win_reg[2] <= key_high_reg[31:0];
            win_reg[3] <= key_high_reg[63:32];
        end
        else if (state_reg == ST_EXP)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= new_word;
            row_buf_reg[32*wcnt_reg[1:0] +: 32] <= mixed_word;
        end
        if (state_reg == ST_IDLE && start)
        begin
            st_reg <= din;
        end
        else if (state_reg == ST_ROUND)
        begin
            if (rnd_reg == 4'd11)
            begin
                // row 10 is read: initial AddRoundKey
                st_reg <= st_reg ^ ram_rdata;
            end
            else if (rnd_reg != 4'd12)
            begin
                st_reg <= rnd_out ^ ram_rdata;
            end
        end
    end

    assign done            = (state_reg == ST_DONE);
    assign dout.plain_low  = {aesd_pkg::bswap32(st_reg[63:32]), aesd_pkg::bswap32(st_reg[31:0])};
    assign dout.plain_high = {aesd_pkg::bswap32(st_reg[127:96]),
                              aesd_pkg::bswap32(st_reg[95:64])};

endmodule
